// ===== rtl/deqrev_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deqrev_pkg
// shared sizes, operation codes and slot arithmetic for the reversible deque
// ----------------------------------------------------------------------------
package deqrev_pkg;

   localparam int unsigned DEPTH      = 16;
   localparam int unsigned DATA_WIDTH = 32;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = CNT_W + 1;

   // beat field widths
   localparam int unsigned MODE_W      = 3;
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned REQ_TDATA_W = ((VALUE_W + 7) / 8) * 8;
   localparam int unsigned RSP_TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_REVERSE    = 3'd4
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_POP
   } state_type;

   // (base + off) modulo DEPTH, off never above DEPTH
   function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/deqrev_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deqrev_ram
// generic single-clock ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
module deqrev_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/double_ended_queue_with_reverse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_with_reverse
// bounded double-ended queue of data words with constant-time order reversal
// ----------------------------------------------------------------------------
// Each request beat carries one operation (push front, push back, pop front,
// pop back, reverse) and yields exactly one response beat with the popped
// word, an ok flag and the entry count after the operation. Words live in a
// circular ram; reverse only toggles a direction flag. Pushes, reverses,
// refused operations and pops on an empty queue load the response register
// on acceptance; a successful pop first goes through the pop wait state for
// the registered ram read. One operation is in flight at a time; a new
// request is taken once the response register is empty or is being drained
// in the same cycle. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module double_ended_queue_with_reverse (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [deqrev_pkg::REQ_TDATA_W-1:0]   req_tdata,  // push_value
   input  wire logic [deqrev_pkg::MODE_W-1:0]        req_tuser,  // mode
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [deqrev_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // popped_value, entry_count
   output logic                                      rsp_tuser   // ok
);

   localparam int unsigned PTR_W = deqrev_pkg::PTR_W;
   localparam int unsigned CNT_W = deqrev_pkg::CNT_W;
   localparam int unsigned DW    = deqrev_pkg::DATA_WIDTH;
   localparam int unsigned VW    = deqrev_pkg::VALUE_W;
   localparam int unsigned CW    = deqrev_pkg::COUNT_W;

   deqrev_pkg::state_type state_ff, state_in;

   logic [PTR_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rev_ff, rev_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]    rsp_value_ff, rsp_value_in;
   logic             rsp_ok_ff, rsp_ok_in;
   logic [CW-1:0]    rsp_count_ff, rsp_count_in;

   logic             req_accept;
   logic             pop_start;
   logic             op_ok;
   logic             at_low;
   logic             is_full;
   logic             is_empty;
   deqrev_pkg::op_type op;

   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr;
   logic [DW-1:0]    rd_data;

   deqrev_ram #(
      .WIDTH (DW),
      .DEPTH (deqrev_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (DW'(req_tdata[VW-1:0])),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // fsm next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         deqrev_pkg::ST_IDLE: begin
            if (pop_start) begin
               state_in = deqrev_pkg::ST_POP;
            end
         end
         deqrev_pkg::ST_POP: begin
            state_in = deqrev_pkg::ST_IDLE;
         end
         default: begin
            state_in = deqrev_pkg::ST_IDLE;
         end
      endcase
   end

   // fsm outputs
   always_comb begin
      req_tready = 1'b0;
      unique case (state_ff)
         deqrev_pkg::ST_IDLE: req_tready = !rsp_valid_ff || rsp_tready;
         deqrev_pkg::ST_POP:  req_tready = 1'b0;
         default:             req_tready = 1'b0;
      endcase
   end

   assign req_accept = req_tvalid && req_tready;
   assign op         = deqrev_pkg::op_type'(req_tuser);
   assign is_full    = (count_ff == CNT_W'(deqrev_pkg::DEPTH));
   assign is_empty   = (count_ff == '0);

   // operation decode, pointer update and ram access
   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      rev_in    = rev_ff;
      op_ok     = 1'b0;
      pop_start = 1'b0;
      at_low    = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = front_ff;
      rd_en     = 1'b0;
      rd_addr   = front_ff;
      if (req_accept) begin
         unique case (op)
            deqrev_pkg::OP_PUSH_FRONT, deqrev_pkg::OP_PUSH_BACK: begin
               at_low = (op == deqrev_pkg::OP_PUSH_FRONT) ^ rev_ff;
               if (!is_full) begin
                  op_ok    = 1'b1;
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  if (at_low) begin
                     wr_addr  = deqrev_pkg::slot_add(front_ff,
                                                     CNT_W'(deqrev_pkg::DEPTH - 1));
                     front_in = wr_addr;
                  end else begin
                     wr_addr = deqrev_pkg::slot_add(front_ff, count_ff);
                  end
               end
            end
            deqrev_pkg::OP_POP_FRONT, deqrev_pkg::OP_POP_BACK: begin
               at_low = (op == deqrev_pkg::OP_POP_FRONT) ^ rev_ff;
               if (!is_empty) begin
                  op_ok     = 1'b1;
                  pop_start = 1'b1;
                  rd_en     = 1'b1;
                  count_in  = count_ff - CNT_W'(1);
                  if (at_low) begin
                     rd_addr  = front_ff;
                     front_in = deqrev_pkg::slot_add(front_ff, CNT_W'(1));
                  end else begin
                     rd_addr = deqrev_pkg::slot_add(front_ff, count_ff - CNT_W'(1));
                  end
               end
            end
            deqrev_pkg::OP_REVERSE: begin
               op_ok  = 1'b1;
               rev_in = !rev_ff;
            end
            default: begin
               op_ok = 1'b0;
            end
         endcase
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == deqrev_pkg::ST_POP) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = VW'(rd_data);
         rsp_ok_in    = 1'b1;
         rsp_count_in = CW'(count_ff);
      end else if (req_accept && !pop_start) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = '0;
         rsp_ok_in    = op_ok;
         rsp_count_in = CW'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deqrev_pkg::ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = deqrev_pkg::RSP_TDATA_W'({rsp_count_ff, rsp_value_ff});

   // pop wait state only after an accepted pop
   a_pop_follows_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == deqrev_pkg::ST_POP |-> $past(req_accept) && $past(pop_start))
      else $error("pop wait state without an accepted pop");

   // occupancy bounded by store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(deqrev_pkg::DEPTH))
      else $error("entry count exceeds depth");

   // a refused operation carries no word
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_value_ff == '0)
      else $error("refused operation returned a word");

   // reverse toggles the direction flag
   a_reverse_toggles: assert property (@(posedge clock) disable iff (reset)
      req_accept && op == deqrev_pkg::OP_REVERSE |=> rev_ff != $past(rev_ff))
      else $error("reverse did not toggle direction");

endmodule
`default_nettype wire
